@@ rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types, codes and constants of the rotary slot indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int COUNTS_PER_TURN_DEF = 34;
  localparam int SLOT_COUNT_DEF      = 6;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Ramp codes
  localparam logic [1:0] RAMP_STEADY = 2'd0;
  localparam logic [1:0] RAMP_ACCEL  = 2'd1;
  localparam logic [1:0] RAMP_DECEL  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ACCEL_STEP  = 3'd0;
  localparam logic [2:0] REG_DECEL_STEP  = 3'd1;
  localparam logic [2:0] REG_START_DUTY  = 3'd2;
  localparam logic [2:0] REG_FLOOR_DUTY  = 3'd3;
  localparam logic [2:0] REG_HOMING_DUTY = 3'd4;
  localparam logic [2:0] REG_SLOWDOWN    = 3'd5;

  // Register reset values
  localparam logic [6:0] ACCEL_STEP_RST  = 7'd4;
  localparam logic [6:0] DECEL_STEP_RST  = 7'd8;
  localparam logic [7:0] START_DUTY_RST  = 8'd135;
  localparam logic [7:0] FLOOR_DUTY_RST  = 8'd103;
  localparam logic [7:0] HOMING_DUTY_RST = 8'd100;
  localparam logic [4:0] SLOWDOWN_RST    = 5'd3;

  localparam logic [7:0] DUTY_MAX = 8'd255;

  typedef struct packed {
    logic [6:0] accel_step;
    logic [6:0] decel_step;
    logic [7:0] start_duty;
    logic [7:0] floor_duty;
    logic [7:0] homing_duty;
    logic [4:0] slowdown_distance;
  } rsi_cfg_t;

  typedef struct packed {
    logic [5:0]      enc_count;
    logic [5:0]      tgt_count;
    logic [2:0]      tgt_slot;
    logic [2:0]      cur_slot;
    logic [2:0]      enc_hist;
    logic            enc_stable;
    logic            enc_last;
    logic [1:0]      ramp;
    logic            running;
    logic            homing;
    logic            forward;
    logic [7:0]      duty;
    logic            reached;
    logic [3:0][3:0] key_hist;
    logic [3:0]      key_stable;
  } rsi_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] target_slot;
    logic       encoder_raw;
    logic       zero_switch;
    logic [3:0] touch_raw;
  } rsi_item_t;

  // Encoder count of each of the first six slots
  function automatic logic [5:0] slot_base_count(input logic [2:0] slot);
    logic [5:0] c;
    case (slot)
      3'd0:    c = 6'd0;
      3'd1:    c = 6'd4;
      3'd2:    c = 6'd11;
      3'd3:    c = 6'd17;
      3'd4:    c = 6'd24;
      3'd5:    c = 6'd29;
      default: c = 6'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rotary_slot_indexer.sv @@
// ----------------------------------------------------------------------------
// rotary_slot_indexer
// Six-slot disc positioner: homing, shortest-way moves, duty ramps,
// encoder and touch key debounce, one result transfer per item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Ports                         Contents
//  in_      slave      tvalid/tready/tdata/tuser     one start, move or tick item
//  out_     master     tvalid/tready/tdata           motor and position status
//  cfg_     APB slave  psel/penable/pwrite/paddr/... six ramp/slowdown registers
//
//  An item passes from input transfer to result through the input register,
//  then through the next-state logic into the state register.
//  One item is accepted per cycle when the output side does not stall.
//  rst_n is synchronous and active low; it clears the state and loads the
//  register reset values.
//  A stalled result holds the state register; the input register still takes
//  one more item and then holds until the result transfer completes.
//
`default_nettype none

module rotary_slot_indexer #(
  parameter int COUNTS_PER_TURN = rsi_pkg::COUNTS_PER_TURN_DEF,
  parameter int SLOT_COUNT      = rsi_pkg::SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] target_slot, [3] encoder_raw, [4] zero_switch, [8:5] touch_raw
  input  wire logic [15:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]  in_tuser,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] motor_on, [1] direction, [9:2] duty, [11:10] ramp_mode,
  // [14:12] slot_position, [15] at_target, [16] homing, [20:17] key_states
  output logic [23:0]      out_tdata,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  rsi_pkg::rsi_cfg_t   cfg;
  rsi_pkg::rsi_state_t state_r;
  rsi_pkg::rsi_state_t state_nxt;
  rsi_pkg::rsi_item_t  item_r;
  logic                item_valid_r;
  logic                out_valid_r;
  logic                advance;

  rsi_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rsi_core #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .SLOT_COUNT      (SLOT_COUNT)
  ) u_core (
    .st   (state_r),
    .cfg  (cfg),
    .item (item_r),
    .nxt  (state_nxt)
  );

  // Advance the held item into the state whenever the result slot is free
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind        <= in_tuser;
      item_r.target_slot <= in_tdata[2:0];
      item_r.encoder_raw <= in_tdata[3];
      item_r.zero_switch <= in_tdata[4];
      item_r.touch_raw   <= in_tdata[8:5];
    end
  end

  // State register doubles as the result register: it only changes when a
  // result transfer is free to start, so a waiting result holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
      if (item_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0,
                       state_r.key_stable,
                       state_r.homing,
                       state_r.reached,
                       state_r.cur_slot,
                       state_r.ramp,
                       state_r.duty,
                       state_r.forward,
                       state_r.running};

endmodule

`default_nettype wire

@@ rtl/rsi_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rsi_cfg_regs
// APB-style register bank holding the ramp and slowdown settings.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [4:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output rsi_pkg::rsi_cfg_t     cfg
);

  rsi_pkg::rsi_cfg_t cfg_r;
  logic [2:0]        idx;
  logic              wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step        <= rsi_pkg::ACCEL_STEP_RST;
      cfg_r.decel_step        <= rsi_pkg::DECEL_STEP_RST;
      cfg_r.start_duty        <= rsi_pkg::START_DUTY_RST;
      cfg_r.floor_duty        <= rsi_pkg::FLOOR_DUTY_RST;
      cfg_r.homing_duty       <= rsi_pkg::HOMING_DUTY_RST;
      cfg_r.slowdown_distance <= rsi_pkg::SLOWDOWN_RST;
    end else if (wr_en) begin
      case (idx)
        rsi_pkg::REG_ACCEL_STEP:  cfg_r.accel_step        <= cfg_pwdata[6:0];
        rsi_pkg::REG_DECEL_STEP:  cfg_r.decel_step        <= cfg_pwdata[6:0];
        rsi_pkg::REG_START_DUTY:  cfg_r.start_duty        <= cfg_pwdata[7:0];
        rsi_pkg::REG_FLOOR_DUTY:  cfg_r.floor_duty        <= cfg_pwdata[7:0];
        rsi_pkg::REG_HOMING_DUTY: cfg_r.homing_duty       <= cfg_pwdata[7:0];
        rsi_pkg::REG_SLOWDOWN:    cfg_r.slowdown_distance <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rsi_pkg::REG_ACCEL_STEP:  cfg_prdata = {25'd0, cfg_r.accel_step};
      rsi_pkg::REG_DECEL_STEP:  cfg_prdata = {25'd0, cfg_r.decel_step};
      rsi_pkg::REG_START_DUTY:  cfg_prdata = {24'd0, cfg_r.start_duty};
      rsi_pkg::REG_FLOOR_DUTY:  cfg_prdata = {24'd0, cfg_r.floor_duty};
      rsi_pkg::REG_HOMING_DUTY: cfg_prdata = {24'd0, cfg_r.homing_duty};
      rsi_pkg::REG_SLOWDOWN:    cfg_prdata = {27'd0, cfg_r.slowdown_distance};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rsi_core.sv @@
// ----------------------------------------------------------------------------
// rsi_core
// Next-state logic: applies one start, move or tick item to the state.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_core #(
  parameter int COUNTS_PER_TURN = rsi_pkg::COUNTS_PER_TURN_DEF,
  parameter int SLOT_COUNT      = rsi_pkg::SLOT_COUNT_DEF
) (
  input  wire rsi_pkg::rsi_state_t st,
  input  wire rsi_pkg::rsi_cfg_t   cfg,
  input  wire rsi_pkg::rsi_item_t  item,
  output rsi_pkg::rsi_state_t      nxt
);

  localparam logic [5:0]        CPT_M1 = 6'(COUNTS_PER_TURN - 1);
  localparam logic [6:0]        CPT_M1_W = 7'(COUNTS_PER_TURN - 1);
  localparam logic [5:0]        CNT6   = 6'((6 * COUNTS_PER_TURN / SLOT_COUNT) % 64);
  localparam logic [5:0]        CNT7   = 6'((7 * COUNTS_PER_TURN / SLOT_COUNT) % 64);
  localparam logic signed [4:0] HALF_S = 5'(SLOT_COUNT / 2);
  localparam logic signed [4:0] SC_S   = 5'(SLOT_COUNT);
  localparam logic [3:0]        SC_W   = 4'(SLOT_COUNT);

  always_comb begin
    logic signed [4:0] rot;
    logic [8:0]        acc_sum;
    logic [7:0]        dec_val;
    logic [6:0]        cnt_w;
    logic [6:0]        tgt_w;
    logic [6:0]        d_w;
    logic [5:0]        cnt;

    nxt     = st;
    rot     = '0;
    acc_sum = {1'b0, st.duty} + {2'b00, cfg.accel_step};
    dec_val = (st.duty > {1'b0, cfg.decel_step}) ? (st.duty - {1'b0, cfg.decel_step}) : 8'd0;
    cnt     = st.enc_count;
    cnt_w   = '0;
    tgt_w   = {1'b0, st.tgt_count};
    d_w     = {2'b00, cfg.slowdown_distance};

    case (item.kind)
      rsi_pkg::KIND_START: begin
        nxt.tgt_count = '0;
        nxt.tgt_slot  = '0;
        if (item.zero_switch) begin
          nxt.enc_count = '0;
          nxt.cur_slot  = '0;
          nxt.homing    = 1'b0;
        end else begin
          nxt.homing  = 1'b1;
          nxt.forward = 1'b1;
          nxt.running = 1'b1;
          nxt.duty    = cfg.homing_duty;
        end
        nxt.enc_hist   = {1'b0, item.encoder_raw, item.encoder_raw};
        nxt.enc_stable = item.encoder_raw;
        nxt.enc_last   = item.encoder_raw;
      end

      rsi_pkg::KIND_MOVE: begin
        if ({1'b0, item.target_slot} < SC_W) begin
          rot = $signed({2'b00, item.target_slot}) - $signed({2'b00, st.cur_slot});
          nxt.tgt_slot = item.target_slot;
          case (item.target_slot)
            3'd6:    nxt.tgt_count = CNT6;
            3'd7:    nxt.tgt_count = CNT7;
            default: nxt.tgt_count = rsi_pkg::slot_base_count(item.target_slot);
          endcase
          nxt.reached = 1'b0;
          // Take the shorter way around the disc
          if (rot > HALF_S) begin
            rot = rot - SC_S;
          end else if (rot < -HALF_S) begin
            rot = rot + SC_S;
          end
          if (rot != 5'sd0) begin
            nxt.forward = (rot > 5'sd0);
            nxt.running = 1'b1;
            nxt.duty    = cfg.start_duty;
            nxt.ramp    = rsi_pkg::RAMP_ACCEL;
          end
          if (rot == 5'sd1 || rot == -5'sd1) begin
            nxt.ramp = rsi_pkg::RAMP_STEADY;
          end
        end
      end

      rsi_pkg::KIND_TICK: begin
        // Duty ramp
        if (st.ramp == rsi_pkg::RAMP_ACCEL) begin
          if (acc_sum >= {1'b0, rsi_pkg::DUTY_MAX}) begin
            nxt.duty = rsi_pkg::DUTY_MAX;
            nxt.ramp = rsi_pkg::RAMP_STEADY;
          end else begin
            nxt.duty = acc_sum[7:0];
          end
        end else if (st.ramp == rsi_pkg::RAMP_DECEL) begin
          nxt.duty = dec_val;
          if (dec_val <= cfg.floor_duty) begin
            nxt.ramp = rsi_pkg::RAMP_STEADY;
          end
        end

        // Encoder debounce
        nxt.enc_hist = {st.enc_hist[1:0], item.encoder_raw};
        if (nxt.enc_hist == 3'b111) begin
          nxt.enc_stable = 1'b1;
        end else if (nxt.enc_hist == 3'b000) begin
          nxt.enc_stable = 1'b0;
        end

        // Touch key debounce, keys are active low
        for (int i = 0; i < 4; i++) begin
          nxt.key_hist[i] = {st.key_hist[i][2:0], item.touch_raw[i]};
          if (nxt.key_hist[i] == 4'b1111) begin
            nxt.key_stable[i] = 1'b0;
          end else if (nxt.key_hist[i] == 4'b0000) begin
            nxt.key_stable[i] = 1'b1;
          end
        end

        if (st.running) begin
          if (item.zero_switch) begin
            nxt.enc_count = '0;
            nxt.cur_slot  = '0;
            nxt.enc_last  = nxt.enc_stable;
            if (st.tgt_slot == 3'd0) begin
              nxt.running = 1'b0;
              nxt.ramp    = rsi_pkg::RAMP_STEADY;
              nxt.duty    = '0;
              nxt.forward = ~st.forward;
              nxt.homing  = 1'b0;
            end
          end
          if ((nxt.enc_stable != nxt.enc_last) && !nxt.homing) begin
            if (st.forward) begin
              cnt = (st.enc_count >= CPT_M1) ? 6'd0 : (st.enc_count + 6'd1);
            end else begin
              cnt = (st.enc_count == 6'd0) ? CPT_M1 : (st.enc_count - 6'd1);
            end
            nxt.enc_count = cnt;
            cnt_w = {1'b0, cnt};
            if (st.tgt_count != 6'd0 && cnt == st.tgt_count) begin
              nxt.running  = 1'b0;
              nxt.ramp     = rsi_pkg::RAMP_STEADY;
              nxt.duty     = '0;
              nxt.forward  = ~st.forward;
              nxt.reached  = 1'b1;
              nxt.cur_slot = st.tgt_slot;
            end else if (st.tgt_count != 6'd0) begin
              if ((cnt_w + d_w == tgt_w) || (cnt_w == tgt_w + d_w)) begin
                nxt.ramp = rsi_pkg::RAMP_DECEL;
              end
            end else begin
              if ((cnt_w + d_w == CPT_M1_W) || (cnt_w == d_w)) begin
                nxt.ramp = rsi_pkg::RAMP_DECEL;
              end
            end
            nxt.enc_last = nxt.enc_stable;
          end
        end
      end

      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks of the rotary slot indexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_checker #(
  parameter int SLOT_COUNT = rsi_pkg::SLOT_COUNT_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  localparam logic [2:0] SLOT_MAX = 3'(SLOT_COUNT - 1);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Stopped motor carries no duty and no ramp
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[9:2] == 8'd0 && out_tdata[11:10] == 2'd0)
    else $error("duty or ramp active with motor off");

  // Homing always drives the motor
  a_homing_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[0])
    else $error("homing without motor drive");

  // Believed slot stays on the disc
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:12] <= SLOT_MAX)
    else $error("slot position out of range");

endmodule

bind rotary_slot_indexer rsi_checker #(.SLOT_COUNT(SLOT_COUNT)) u_rsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
